### sv/ppm_p6_stream_parser_assert.svh
// assertion macros for the ppm p6 parser checks
`ifndef PPM_P6_STREAM_PARSER_ASSERT_SVH
`define PPM_P6_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PPM_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ppm_p6 parser check failed");

// next-cycle implication
`define PPM_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ppm_p6 parser check failed");

`endif

### sv/ppm_p6_pkg.sv
package ppm_p6_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam logic [31:0] MAX_BYTES_RST = 32'd100000000;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_MAGIC     = 2'd0;
	localparam logic [1:0] ERR_DIGIT     = 2'd1;
	localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
	localparam logic [1:0] ERR_MAX_COLOR = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  error_code;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last_pixel;
	} out_item_t;

endpackage

### sv/ppm_p6_stream_parser.sv
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall   in_data (data_byte, start_req)
// out       source     out_valid/out_stall out_data (header, pixel or error)
// cfg       sink       cfg_wr_en           cfg_wr_data (max_bytes)
//
// one byte accepted per cycle while in_stall is low; a result is registered and shows on out the cycle after its byte
// the pixel size check runs incrementally as height digits arrive, no multi-cycle unit
// arst_n clears parser state to idle and max_bytes to its default, no clearing pass
// in_stall rises only while a result is held on out under out_stall
module ppm_p6_stream_parser
	import ppm_p6_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	localparam int AW  = DIM_BITS + 1;
	localparam int AMW = AW + 4;
	localparam int W3W = DIM_BITS + 2;
	localparam int WDW = DIM_BITS + 6;
	localparam int PTW = 37;

	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_6   = 8'h36;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [AW-1:0] COLOR_MAX = AW'(255);

	typedef enum logic [13:0] {
		PH_IDLE      = 14'h0001,
		PH_MAG0      = 14'h0002,
		PH_MAG1_OK   = 14'h0004,
		PH_MAG1_BAD  = 14'h0008,
		PH_WSKIP     = 14'h0010,
		PH_WDIG      = 14'h0020,
		PH_HSKIP     = 14'h0040,
		PH_HDIG      = 14'h0080,
		PH_HSKIP_BIG = 14'h0100,
		PH_HDIG_BIG  = 14'h0200,
		PH_CSKIP     = 14'h0400,
		PH_CDIG      = 14'h0800,
		PH_PIX       = 14'h1000,
		PH_DONE      = 14'h2000
	} phase_t;

	phase_t              phase_q, ph, phase_d;
	logic [31:0]         max_bytes_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic [AW-1:0]       accum_q, accum_d;
	logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
	logic [W3W-1:0]      w3_q, w3_d;
	logic [31:0]         prod_q, prod_d;
	logic                prod_ovf_q, prod_ovf_d;
	logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;
	logic [1:0]          bip_q, bip_d;
	logic [7:0]          red_q, red_d, green_q, green_d;

	logic [7:0]          b;
	logic                is_ws, is_digit;
	logic [3:0]          dig;
	logic [AMW-1:0]      acc_sum;
	logic [AW-1:0]       acc_next;
	logic                acc_over;
	logic [DIM_BITS-1:0] acc_clamp;
	logic [WDW-1:0]      wd;
	logic [PTW-1:0]      prod_sum;
	logic [DIM_BITS:0]   col_inc, row_inc;
	logic                fire;
	logic                err_v, hdr_v, pix_v, pix_last;
	logic [1:0]          err_c;
	out_item_t           res;
	logic                res_v;

	assign fire      = in_valid & ~in_stall;
	assign in_stall  = out_valid_q & out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign b        = in_data.data_byte;
	assign is_ws    = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
	assign is_digit = (b >= CH_0) && (b <= CH_9);
	assign dig      = b[3:0];

	// accumulator times ten plus digit, saturating at 2^DIM_BITS
	assign acc_sum  = (AMW'(accum_q) << 3) + (AMW'(accum_q) << 1) + AMW'(dig);
	assign acc_next = (acc_sum > (AMW'(1) << DIM_BITS)) ? (AW'(1) << DIM_BITS)
		: acc_sum[AW-1:0];
	assign acc_over  = accum_q[DIM_BITS];
	assign acc_clamp = acc_over ? '1 : accum_q[DIM_BITS-1:0];

	// running width*height*3, tracked digit by digit along the height
	assign wd       = WDW'(w3_q) * WDW'(dig);
	assign prod_sum = (PTW'(prod_q) << 3) + (PTW'(prod_q) << 1) + PTW'(wd);

	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;

	always_comb begin
		ph         = in_data.start_req ? PH_MAG0 : phase_q;
		phase_d    = ph;
		accum_d    = accum_q;
		width_d    = width_q;
		height_d   = height_q;
		w3_d       = w3_q;
		prod_d     = prod_q;
		prod_ovf_d = prod_ovf_q;
		col_d      = col_q;
		row_d      = row_q;
		bip_d      = bip_q;
		red_d      = red_q;
		green_d    = green_q;
		err_v      = 1'b0;
		err_c      = ERR_MAGIC;
		hdr_v      = 1'b0;
		pix_v      = 1'b0;
		pix_last   = 1'b0;
		unique case (ph)
			PH_MAG0: phase_d = (b == CH_P) ? PH_MAG1_OK : PH_MAG1_BAD;
			PH_MAG1_OK: begin
				if (b == CH_6) phase_d = PH_WSKIP;
				else err_v = 1'b1;
			end
			PH_MAG1_BAD: err_v = 1'b1;
			PH_WSKIP, PH_CSKIP: begin
				if (is_digit) begin
					accum_d = AW'(dig);
					phase_d = (ph == PH_WSKIP) ? PH_WDIG : PH_CDIG;
				end else if (!is_ws) begin
					err_v = 1'b1;
					err_c = ERR_DIGIT;
				end
			end
			PH_HSKIP, PH_HSKIP_BIG: begin
				if (is_digit) begin
					accum_d    = AW'(dig);
					prod_d     = 32'(wd);
					prod_ovf_d = 1'b0;
					phase_d    = (ph == PH_HSKIP) ? PH_HDIG : PH_HDIG_BIG;
				end else if (!is_ws) begin
					err_v = 1'b1;
					err_c = ERR_DIGIT;
				end
			end
			PH_WDIG: begin
				if (is_digit) begin
					accum_d = acc_next;
				end else begin
					width_d = acc_clamp;
					w3_d    = (W3W'(acc_clamp) << 1) + W3W'(acc_clamp);
					phase_d = acc_over ? PH_HSKIP_BIG : PH_HSKIP;
				end
			end
			PH_HDIG, PH_HDIG_BIG: begin
				if (is_digit) begin
					accum_d    = acc_next;
					prod_d     = prod_sum[31:0];
					prod_ovf_d = prod_ovf_q || (prod_sum[PTW-1:32] != '0);
				end else begin
					height_d = acc_clamp;
					if ((ph == PH_HDIG_BIG) || acc_over || prod_ovf_q
							|| (prod_q > max_bytes_q)) begin
						err_v = 1'b1;
						err_c = ERR_TOO_LARGE;
					end else begin
						phase_d = PH_CSKIP;
					end
				end
			end
			PH_CDIG: begin
				if (is_digit) begin
					accum_d = acc_next;
				end else if (accum_q != COLOR_MAX) begin
					err_v = 1'b1;
					err_c = ERR_MAX_COLOR;
				end else begin
					hdr_v   = 1'b1;
					col_d   = '0;
					row_d   = '0;
					bip_d   = 2'd0;
					phase_d = ((width_q == '0) || (height_q == '0)) ? PH_DONE : PH_PIX;
				end
			end
			PH_PIX: begin
				case (bip_q)
					2'd0: begin
						red_d = b;
						bip_d = 2'd1;
					end
					2'd1: begin
						green_d = b;
						bip_d   = 2'd2;
					end
					default: begin
						pix_v = 1'b1;
						bip_d = 2'd0;
						if (col_inc >= {1'b0, width_q}) begin
							col_d = '0;
							if (row_inc >= {1'b0, height_q}) begin
								pix_last = 1'b1;
								phase_d  = PH_DONE;
							end else begin
								row_d = row_inc[DIM_BITS-1:0];
							end
						end else begin
							col_d = col_inc[DIM_BITS-1:0];
						end
					end
				endcase
			end
			default: ;
		endcase
		if (err_v) phase_d = PH_DONE;

		res   = '0;
		res_v = err_v | hdr_v | pix_v;
		if (err_v) begin
			res.kind       = KIND_ERROR;
			res.error_code = err_c;
		end else if (hdr_v) begin
			res.kind         = KIND_HEADER;
			res.image_width  = 16'(width_q);
			res.image_height = 16'(height_q);
		end else if (pix_v) begin
			res.kind         = KIND_PIXEL;
			res.image_width  = 16'(width_q);
			res.image_height = 16'(height_q);
			res.pos_x        = 16'(col_q);
			res.pos_y        = 16'(row_q);
			res.red          = red_q;
			res.green        = green_q;
			res.blue         = b;
			res.last_pixel   = pix_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			max_bytes_q <= MAX_BYTES_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) max_bytes_q <= cfg_wr_data;
			if (fire) phase_q <= phase_d;
			if (!out_valid_q || !out_stall) out_valid_q <= fire & res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accum_q    <= accum_d;
			width_q    <= width_d;
			height_q   <= height_d;
			w3_q       <= w3_d;
			prod_q     <= prod_d;
			prod_ovf_q <= prod_ovf_d;
			col_q      <= col_d;
			row_q      <= row_d;
			bip_q      <= bip_d;
			red_q      <= red_d;
			green_q    <= green_d;
		end
		if (fire && res_v) out_data_q <= res;
	end

endmodule

### sv/ppm_p6_checker.sv
`include "ppm_p6_stream_parser_assert.svh"

module ppm_p6_checker
	import ppm_p6_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	logic err_beat, hdr_beat;

	assign err_beat = out_valid && (out_data.kind == KIND_ERROR);
	assign hdr_beat = out_valid && (out_data.kind == KIND_HEADER);

	// a held result beat stays put
	`PPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// input backs up only behind a held result
	`PPM_ASSERT_IMPL(a_stall_src, in_stall, out_valid && out_stall)

	`PPM_ASSERT_IMPL(a_err_clean, err_beat, out_data.image_width == '0 && !out_data.last_pixel)

	`PPM_ASSERT_IMPL(a_hdr_clean, hdr_beat, out_data.pos_x == '0 && !out_data.last_pixel)

endmodule

bind ppm_p6_stream_parser ppm_p6_checker u_ppm_p6_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/ppm_p6_stream_parser_tb.sv
`timescale 1ns / 100ps

module ppm_p6_stream_parser_tb
	import ppm_p6_pkg::*;
;

	localparam int DIM_BITS = DIM_BITS_DEF;
	localparam int unsigned DIM_CAP = 1 << DIM_BITS;
	localparam int unsigned DIM_MAX = DIM_CAP - 1;
	localparam int unsigned COLOR_MAX = 255;

	localparam logic [7:0] WS_CHARS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAG0, ST_MAG1_OK, ST_MAG1_BAD,
		ST_W_SKIP, ST_W_DIG, ST_H_SKIP, ST_H_DIG, ST_H_SKIP_BIG, ST_H_DIG_BIG,
		ST_C_SKIP, ST_C_DIG, ST_PIX, ST_DONE
	} parse_st_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sop;
		logic       typed;
		out_item_t  want;
	} stim_row_t;

	localparam out_item_t EXP_MAGIC = '{kind: KIND_ERROR, error_code: ERR_MAGIC, default: '0};
	localparam out_item_t EXP_DIGIT = '{kind: KIND_ERROR, error_code: ERR_DIGIT, default: '0};
	localparam out_item_t EXP_BIG = '{kind: KIND_ERROR, error_code: ERR_TOO_LARGE, default: '0};
	localparam out_item_t EXP_HDR_0X1 = '{kind: KIND_HEADER, image_height: 16'd1, default: '0};
	localparam out_item_t EXP_HDR_1X1 =
		'{kind: KIND_HEADER, image_width: 16'd1, image_height: 16'd1, default: '0};

	localparam int DIR_ROWS = 43;
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		// byte before any start is dropped
		'{"X", 1'b0, 1'b0, '0},
		// bad magic, then a beat after the error
		'{"Q", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b1, EXP_MAGIC},
		'{"6", 1'b0, 1'b0, '0},
		// restart in mid-stream, then a non-digit where the width belongs
		'{"P", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b0, '0},
		'{"P", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b0, '0},
		'{"+", 1'b0, 1'b1, EXP_DIGIT},
		// zero width: header and nothing else
		'{"P", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"x", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{"2", 1'b0, 1'b0, '0},
		'{"5", 1'b0, 1'b0, '0},
		'{"5", 1'b0, 1'b0, '0},
		'{8'h0d, 1'b0, 1'b1, EXP_HDR_0X1},
		// one pixel, red and green at the channel extremes
		'{"P", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b0, '0},
		'{8'h09, 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{" ", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{8'h0a, 1'b0, 1'b0, '0},
		'{"2", 1'b0, 1'b0, '0},
		'{"5", 1'b0, 1'b0, '0},
		'{"5", 1'b0, 1'b0, '0},
		'{" ", 1'b0, 1'b1, EXP_HDR_1X1},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// width saturates the accumulator
		'{"P", 1'b1, 1'b0, '0},
		'{"6", 1'b0, 1'b0, '0},
		'{"7", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{" ", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b1, EXP_BIG}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	// parser copy
	parse_st_t   pst = ST_IDLE;
	int unsigned num_acc = 0;
	int unsigned img_w = 0;
	int unsigned img_h = 0;
	int unsigned col = 0;
	int unsigned row = 0;
	int unsigned chan_idx = 0;
	logic [7:0]  r_hold = '0;
	logic [7:0]  g_hold = '0;
	logic [31:0] lim_bytes = MAX_BYTES_RST;
	out_item_t   predicted;

	out_item_t   pending_parse_results[$];
	logic [7:0]  file_bytes[$];
	bit          calm = 1'b0;
	int          err_count = 0;
	int          live_beats = 0;
	int          idle_beats = 0;
	int          cfg_writes = 0;
	int          n_hdr = 0;
	int          n_pix = 0;
	int          n_err = 0;

	ppm_p6_stream_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic bit is_ws(input int unsigned b);
		return b == " " || (b >= 9 && b <= 13);
	endfunction

	function automatic bit is_dig(input int unsigned b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit raise(input logic [1:0] code);
		predicted = '0;
		predicted.kind = KIND_ERROR;
		predicted.error_code = code;
		pst = ST_DONE;
		return 1'b1;
	endfunction

	function automatic bit skip_to(input int unsigned b, input parse_st_t nxt);
		if (is_ws(b))
			return 1'b0;
		if (is_dig(b)) begin
			num_acc = b - "0";
			pst = nxt;
			return 1'b0;
		end
		return raise(ERR_DIGIT);
	endfunction

	function automatic void add_digit(input int unsigned b);
		int unsigned v;
		v = num_acc * 10 + (b - "0");
		num_acc = (v > DIM_CAP) ? DIM_CAP : v;
	endfunction

	// advances the parser copy by one beat, fills predicted when a result is due
	function automatic bit parse_byte(input in_item_t it);
		int unsigned b;
		longint unsigned area;
		bit hit;
		b = it.data_byte;
		hit = 1'b0;
		predicted = '0;
		if (it.start_req) begin
			pst = ST_MAG0;
			num_acc = 0;
			img_w = 0;
			img_h = 0;
			col = 0;
			row = 0;
			chan_idx = 0;
			r_hold = '0;
			g_hold = '0;
		end
		case (pst)
			ST_MAG0: pst = (b == "P") ? ST_MAG1_OK : ST_MAG1_BAD;
			ST_MAG1_OK: begin
				if (b == "6")
					pst = ST_W_SKIP;
				else
					hit = raise(ERR_MAGIC);
			end
			ST_MAG1_BAD: hit = raise(ERR_MAGIC);
			ST_W_SKIP: hit = skip_to(b, ST_W_DIG);
			ST_W_DIG: begin
				if (is_dig(b)) begin
					add_digit(b);
				end else begin
					img_w = (num_acc > DIM_MAX) ? DIM_MAX : num_acc;
					pst = (num_acc > DIM_MAX) ? ST_H_SKIP_BIG : ST_H_SKIP;
				end
			end
			ST_H_SKIP: hit = skip_to(b, ST_H_DIG);
			ST_H_SKIP_BIG: hit = skip_to(b, ST_H_DIG_BIG);
			ST_H_DIG, ST_H_DIG_BIG: begin
				if (is_dig(b)) begin
					add_digit(b);
				end else begin
					img_h = (num_acc > DIM_MAX) ? DIM_MAX : num_acc;
					area = img_w;
					area = area * img_h * 3;
					if (pst == ST_H_DIG_BIG || num_acc > DIM_MAX || area > lim_bytes)
						hit = raise(ERR_TOO_LARGE);
					else
						pst = ST_C_SKIP;
				end
			end
			ST_C_SKIP: hit = skip_to(b, ST_C_DIG);
			ST_C_DIG: begin
				if (is_dig(b)) begin
					add_digit(b);
				end else if (num_acc != COLOR_MAX) begin
					hit = raise(ERR_MAX_COLOR);
				end else begin
					predicted.kind = KIND_HEADER;
					predicted.image_width = img_w[15:0];
					predicted.image_height = img_h[15:0];
					col = 0;
					row = 0;
					chan_idx = 0;
					pst = (img_w == 0 || img_h == 0) ? ST_DONE : ST_PIX;
					hit = 1'b1;
				end
			end
			ST_PIX: begin
				if (chan_idx == 0) begin
					r_hold = b[7:0];
					chan_idx = 1;
				end else if (chan_idx == 1) begin
					g_hold = b[7:0];
					chan_idx = 2;
				end else begin
					predicted.kind = KIND_PIXEL;
					predicted.image_width = img_w[15:0];
					predicted.image_height = img_h[15:0];
					predicted.pos_x = col[15:0];
					predicted.pos_y = row[15:0];
					predicted.red = r_hold;
					predicted.green = g_hold;
					predicted.blue = b[7:0];
					chan_idx = 0;
					hit = 1'b1;
					if (col + 1 >= img_w) begin
						col = 0;
						if (row + 1 >= img_h) begin
							predicted.last_pixel = 1'b1;
							pst = ST_DONE;
						end else begin
							row = row + 1;
						end
					end else begin
						col = col + 1;
					end
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	// returns at the edge that took the beat; the caller drives the next one in the same step
	task automatic push_beat(input in_item_t it, input bit typed, input out_item_t want);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (!it.start_req && (pst == ST_IDLE || pst == ST_DONE))
			idle_beats++;
		else
			live_beats++;
		if (parse_byte(it) && !typed)
			pending_parse_results.push_back(predicted);
		if (typed)
			pending_parse_results.push_back(want);
	endtask

	task automatic set_max_bytes(input logic [31:0] v);
		in_valid <= 1'b0;
		while (pending_parse_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lim_bytes = v;
		cfg_writes++;
	endtask

	// optional whitespace, maybe leading zeros, the digits, one terminator
	task automatic add_field(input longint unsigned v);
		logic [7:0] digs[$];
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) file_bytes.push_back(WS_CHARS[$urandom_range(0, 5)]);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) file_bytes.push_back("0");
		do begin
			digs.push_front("0" + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			file_bytes.push_back(digs[i]);
		if ($urandom_range(0, 4) == 0) begin
			do b = 8'($urandom); while (is_dig(b));
		end else begin
			b = WS_CHARS[$urandom_range(0, 5)];
		end
		file_bytes.push_back(b);
	endtask

	task automatic send_random_file();
		int unsigned flaw;
		longint unsigned w;
		longint unsigned h;
		longint unsigned mc;
		logic [7:0] b;
		bit broken;
		file_bytes.delete();
		broken = ($urandom_range(0, 4) == 0);
		flaw = $urandom_range(0, 4);
		w = $urandom_range(1, 5);
		h = $urandom_range(1, 4);
		case ($urandom_range(0, 19))
			0: w = $urandom_range(65536, 3000000);
			1: h = $urandom_range(65536, 3000000);
			2: begin
				w = 0;
				h = $urandom_range(0, DIM_MAX);
			end
			3: begin
				w = DIM_MAX;
				h = 0;
			end
			4: begin
				w = $urandom_range(100, DIM_MAX);
				h = $urandom_range(100, DIM_MAX);
				if ($urandom_range(0, 3) == 0) begin
					w = DIM_MAX;
					h = DIM_MAX;
				end
				// keep accepted big images pixel-free
				if (w * h * 3 <= lim_bytes)
					h = 0;
			end
			default: ;
		endcase
		mc = COLOR_MAX;
		if (broken && flaw == 3) begin
			case ($urandom_range(0, 3))
				0: mc = 0;
				1: mc = COLOR_MAX - 1;
				2: mc = COLOR_MAX + 1;
				default: mc = $urandom_range(0, 3000000);
			endcase
		end
		file_bytes.push_back("P");
		file_bytes.push_back("6");
		if (broken && flaw == 0) begin
			do b = 8'($urandom); while (b == "P");
			file_bytes[0] = b;
		end
		if (broken && flaw == 1) begin
			do b = 8'($urandom); while (b == "6");
			file_bytes[1] = b;
		end
		if (broken && flaw == 2) begin
			do b = 8'($urandom); while (is_ws(b) || is_dig(b));
			file_bytes.push_back(b);
		end else begin
			add_field(w);
			add_field(h);
			add_field(mc);
			if (w * h <= 20)
				repeat (w * h * 3) file_bytes.push_back(8'($urandom));
		end
		// cut short: the next start lands in mid-stream
		if (broken && flaw == 4) begin
			b = 8'($urandom_range(1, file_bytes.size() - 1));
			while (file_bytes.size() > b) void'(file_bytes.pop_back());
		end
		foreach (file_bytes[i])
			push_beat('{data_byte: file_bytes[i], start_req: (i == 0)}, 1'b0, '0);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				push_beat('{data_byte: 8'($urandom), start_req: 1'b0}, 1'b0, '0);
	endtask

	task automatic cmp(input string name, input longint unsigned want, input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	initial begin
		int unsigned stall_left;
		out_item_t want;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				case (out_data.kind)
					KIND_HEADER: n_hdr++;
					KIND_PIXEL: n_pix++;
					KIND_ERROR: n_err++;
					default: ;
				endcase
				if (pending_parse_results.size() == 0) begin
					$error("result beat with nothing pending: kind %0d", out_data.kind);
					err_count++;
				end else begin
					want = pending_parse_results.pop_front();
					cmp("kind", want.kind, out_data.kind);
					cmp("error_code", want.error_code, out_data.error_code);
					cmp("image_width", want.image_width, out_data.image_width);
					cmp("image_height", want.image_height, out_data.image_height);
					cmp("pos_x", want.pos_x, out_data.pos_x);
					cmp("pos_y", want.pos_y, out_data.pos_y);
					cmp("red", want.red, out_data.red);
					cmp("green", want.green, out_data.green);
					cmp("blue", want.blue, out_data.blue);
					cmp("last_pixel", want.last_pixel, out_data.last_pixel);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int goal;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			push_beat('{data_byte: DIR_TAB[i].data, start_req: DIR_TAB[i].sop},
				DIR_TAB[i].typed, DIR_TAB[i].want);

		for (int p = 0; p < 6; p++) begin
			case (p)
				1: set_max_bytes(32'd0);
				2: set_max_bytes(32'hffff_ffff);
				3: set_max_bytes(32'd45);
				4: set_max_bytes($urandom_range(1, 90));
				5: set_max_bytes(MAX_BYTES_RST);
				default: ;
			endcase
			calm = (p == 5);
			goal = live_beats + 340;
			while (live_beats < goal) send_random_file();
		end

		in_valid <= 1'b0;
		while (pending_parse_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("parsed %0d file bytes (%0d more dropped while idle) over %0d max_bytes settings",
			live_beats, idle_beats, cfg_writes + 1);
		$display("results seen: %0d headers, %0d pixels, %0d errors", n_hdr, n_pix, n_err);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
